/* rtl/core/cmcr_pkg.sv */
`default_nettype none
package cmcr_pkg;

   // display geometry
   localparam int NUM_MODULES    = 4;
   localparam int MODULE_COLUMNS = 8;
   localparam int TOTAL_COLUMNS  = NUM_MODULES * MODULE_COLUMNS;
   localparam int GCOL_W         = $clog2(TOTAL_COLUMNS);
   localparam int MOD_W          = $clog2(NUM_MODULES);
   localparam int COL_W          = $clog2(MODULE_COLUMNS);

   // transaction field widths
   localparam int HOURS_W   = 5;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;
   localparam int TEMP_W    = 7;
   localparam int FIELD_W   = 2;
   localparam int BITS_W    = 8;
   localparam int DIGIT_W   = 4;

   localparam logic [GCOL_W-1:0] LAST_GCOL = GCOL_W'(TOTAL_COLUMNS - 1);

   // edit field codes
   localparam logic [FIELD_W-1:0] EDIT_HOURS   = 2'd0;
   localparam logic [FIELD_W-1:0] EDIT_MINUTES = 2'd1;
   localparam logic [FIELD_W-1:0] EDIT_SECONDS = 2'd2;

   localparam logic [TEMP_W-1:0] TEMP_MAX = 7'd99;

   // global column layout
   localparam logic [GCOL_W-1:0] HOUR_END_COL     = 5'd7;
   localparam logic [GCOL_W-1:0] COLON1_COL       = 5'd8;
   localparam logic [GCOL_W-1:0] MIN_TENS_COL     = 5'd11;
   localparam logic [GCOL_W-1:0] MIN_UNITS_COL    = 5'd15;
   localparam logic [GCOL_W-1:0] MIN_END_COL      = 5'd18;
   localparam logic [GCOL_W-1:0] COLON2_COL       = 5'd19;
   localparam logic [GCOL_W-1:0] SEC_TENS_COL     = 5'd22;
   localparam logic [GCOL_W-1:0] SEC_UNITS_COL    = 5'd26;
   localparam logic [GCOL_W-1:0] SEC_END_COL      = 5'd29;
   localparam logic [GCOL_W-1:0] TEMP_TENS_COL    = 5'd21;
   localparam logic [GCOL_W-1:0] TEMP_UNITS_COL   = 5'd24;
   localparam logic [GCOL_W-1:0] TEMP_END_COL     = 5'd26;
   localparam logic [GCOL_W-1:0] DEGC_COL         = 5'd28;

   // glyph tables, one byte per column
   localparam logic [BITS_W-1:0] BIG_GLYPH [0:9][0:3] = '{
      '{8'h3E, 8'h41, 8'h41, 8'h3E},
      '{8'h11, 8'h21, 8'h7F, 8'h01},
      '{8'h33, 8'h45, 8'h49, 8'h31},
      '{8'h22, 8'h49, 8'h49, 8'h36},
      '{8'h70, 8'h08, 8'h08, 8'h7F},
      '{8'h72, 8'h51, 8'h51, 8'h4E},
      '{8'h3E, 8'h49, 8'h49, 8'h26},
      '{8'h40, 8'h40, 8'h40, 8'h7F},
      '{8'h36, 8'h49, 8'h49, 8'h36},
      '{8'h32, 8'h49, 8'h49, 8'h3E}
   };

   localparam logic [BITS_W-1:0] SMALL_GLYPH [0:9][0:2] = '{
      '{8'h1F, 8'h11, 8'h1F},
      '{8'h09, 8'h1F, 8'h01},
      '{8'h17, 8'h15, 8'h1D},
      '{8'h15, 8'h15, 8'h1F},
      '{8'h1C, 8'h04, 8'h1F},
      '{8'h1D, 8'h15, 8'h17},
      '{8'h1F, 8'h15, 8'h17},
      '{8'h10, 8'h17, 8'h18},
      '{8'h1F, 8'h15, 8'h1F},
      '{8'h1D, 8'h15, 8'h1F}
   };

   localparam logic [BITS_W-1:0] COLON_GLYPH [0:2] = '{8'h00, 8'h14, 8'h00};
   localparam logic [BITS_W-1:0] DEGC_GLYPH  [0:3] = '{8'h18, 8'h18, 8'h07, 8'h05};

   // digits and blanking of one refresh
   typedef struct packed {
      logic [DIGIT_W-1:0] hour_tens;
      logic [DIGIT_W-1:0] hour_units;
      logic [DIGIT_W-1:0] min_tens;
      logic [DIGIT_W-1:0] min_units;
      logic [DIGIT_W-1:0] sec_tens;
      logic [DIGIT_W-1:0] sec_units;
      logic [DIGIT_W-1:0] temp_tens;
      logic [DIGIT_W-1:0] temp_units;
      logic               temp_mode;
      logic               hide_hours;
      logic               hide_minutes;
      logic               hide_seconds;
   } frame_type;

   // tens and units of a value below 128, reciprocal multiply by 205/2048
   function automatic logic [2*DIGIT_W-1:0] split_digits(input logic [TEMP_W-1:0] value);
      logic [14:0]        prod;
      logic [DIGIT_W-1:0] tens;
      logic [TEMP_W-1:0]  units;
      prod  = 15'(value) * 15'd205;
      tens  = prod[14:11];
      units = value - TEMP_W'(tens) * 7'd10;
      return {tens, units[DIGIT_W-1:0]};
   endfunction

endpackage
`default_nettype wire

/* rtl/core/cmcr_req_if.sv */
`default_nettype none
interface cmcr_req_if import cmcr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [HOURS_W-1:0]   hours;
   logic [MINUTES_W-1:0] minutes;
   logic [SECONDS_W-1:0] seconds;
   logic [TEMP_W-1:0]    temperature;
   logic                 show_temperature;
   logic                 blink_phase;
   logic                 editing;
   logic [FIELD_W-1:0]   edit_field;

   modport source (output valid, hours, minutes, seconds, temperature, show_temperature,
                   blink_phase, editing, edit_field, input ready);
   modport sink   (input valid, hours, minutes, seconds, temperature, show_temperature,
                   blink_phase, editing, edit_field, output ready);
endinterface
`default_nettype wire

/* rtl/core/cmcr_rsp_if.sv */
`default_nettype none
interface cmcr_rsp_if import cmcr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MOD_W-1:0]  module_index;
   logic [COL_W-1:0]  column_index;
   logic [BITS_W-1:0] column_bits;
   logic              last;

   modport source (output valid, module_index, column_index, column_bits, last, input ready);
   modport sink   (input valid, module_index, column_index, column_bits, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/cmcr_column_gen.sv */
`default_nettype none
module cmcr_column_gen import cmcr_pkg::*; (
   input  wire frame_type          frame,
   input  wire logic [GCOL_W-1:0]  gcol,
   output logic [BITS_W-1:0]       column_bits
);

   logic [GCOL_W-1:0] rel_colon1;
   logic [GCOL_W-1:0] rel_min;
   logic [GCOL_W-1:0] rel_colon2;
   logic [GCOL_W-1:0] rel_sec;
   logic [GCOL_W-1:0] rel_temp_tens;
   logic [GCOL_W-1:0] rel_temp_units;

   // offsets from each glyph origin
   assign rel_colon1     = gcol - COLON1_COL;
   assign rel_min        = gcol - MIN_TENS_COL;
   assign rel_colon2     = gcol - COLON2_COL;
   assign rel_sec        = gcol - SEC_TENS_COL;
   assign rel_temp_tens  = gcol - TEMP_TENS_COL;
   assign rel_temp_units = gcol - TEMP_UNITS_COL;

   // pick the glyph byte that covers this column
   always_comb begin
      column_bits = '0;
      if (gcol <= HOUR_END_COL) begin
         if (!frame.hide_hours) begin
            column_bits = gcol[2] ? BIG_GLYPH[frame.hour_units][gcol[1:0]]
                                  : BIG_GLYPH[frame.hour_tens][gcol[1:0]];
         end
      end else if (gcol < MIN_TENS_COL) begin
         column_bits = COLON_GLYPH[rel_colon1[1:0]];
      end else if (gcol <= MIN_END_COL) begin
         if (!frame.hide_minutes) begin
            column_bits = (gcol >= MIN_UNITS_COL) ? BIG_GLYPH[frame.min_units][rel_min[1:0]]
                                                  : BIG_GLYPH[frame.min_tens][rel_min[1:0]];
         end
      end else if (frame.temp_mode) begin
         // small temperature digits and degree glyph
         if (gcol >= TEMP_TENS_COL && gcol < TEMP_UNITS_COL) begin
            column_bits = SMALL_GLYPH[frame.temp_tens][rel_temp_tens[1:0]];
         end else if (gcol >= TEMP_UNITS_COL && gcol <= TEMP_END_COL) begin
            column_bits = SMALL_GLYPH[frame.temp_units][rel_temp_units[1:0]];
         end else if (gcol >= DEGC_COL) begin
            column_bits = DEGC_GLYPH[gcol[1:0]];
         end
      end else begin
         // seconds colon and large seconds digits
         if (gcol < SEC_TENS_COL) begin
            column_bits = COLON_GLYPH[rel_colon2[1:0]];
         end else if (gcol <= SEC_END_COL && !frame.hide_seconds) begin
            column_bits = (gcol >= SEC_UNITS_COL) ? BIG_GLYPH[frame.sec_units][rel_sec[1:0]]
                                                  : BIG_GLYPH[frame.sec_tens][rel_sec[1:0]];
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/core/clock_matrix_column_renderer_core.sv */
`default_nettype none
// after a refresh is accepted, its first column is loaded once the output register is free
// one column per cycle through the single output register unless the output stalls
// the next refresh is accepted in the cycle the 32nd column is loaded, so refreshes run gapless
// reset (synchronous, active high) drops the column sequencer and the output valid
module clock_matrix_column_renderer_core import cmcr_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   cmcr_req_if.sink    req_bus,
   cmcr_rsp_if.source  rsp_bus
);

   logic              busy_ff, busy_in;
   logic [GCOL_W-1:0] gcol_ff, gcol_in;
   frame_type         frame_ff, frame_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GCOL_W-1:0] rsp_gcol_ff, rsp_gcol_in;
   logic [BITS_W-1:0] rsp_bits_ff, rsp_bits_in;

   logic              load;
   logic              req_fire;
   logic              blink;
   logic [TEMP_W-1:0] temp_clip;
   logic [BITS_W-1:0] col_bits;

   // handshake
   assign load          = busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !busy_ff || (load && gcol_ff == LAST_GCOL);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // digit split and blanking of an incoming transaction
   assign blink     = req_bus.blink_phase && req_bus.editing;
   assign temp_clip = (req_bus.temperature > TEMP_MAX) ? TEMP_MAX : req_bus.temperature;

   always_comb begin
      frame_in = frame_ff;
      if (req_fire) begin
         {frame_in.hour_tens, frame_in.hour_units} = split_digits(TEMP_W'(req_bus.hours));
         {frame_in.min_tens,  frame_in.min_units}  = split_digits(TEMP_W'(req_bus.minutes));
         {frame_in.sec_tens,  frame_in.sec_units}  = split_digits(TEMP_W'(req_bus.seconds));
         {frame_in.temp_tens, frame_in.temp_units} = split_digits(temp_clip);
         frame_in.temp_mode    = req_bus.show_temperature;
         frame_in.hide_hours   = blink && req_bus.edit_field == EDIT_HOURS;
         frame_in.hide_minutes = blink && req_bus.edit_field == EDIT_MINUTES;
         frame_in.hide_seconds = blink && req_bus.edit_field == EDIT_SECONDS;
      end
   end

   // column generation for the current sequencer position
   cmcr_column_gen u_column_gen (
      .frame       (frame_ff),
      .gcol        (gcol_ff),
      .column_bits (col_bits)
   );

   // column sequencer
   always_comb begin
      busy_in = busy_ff;
      gcol_in = gcol_ff;
      if (load) begin
         gcol_in = gcol_ff + 1'b1;
         if (gcol_ff == LAST_GCOL) begin
            busy_in = 1'b0;
         end
      end
      if (req_fire) begin
         busy_in = 1'b1;
         gcol_in = '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_gcol_in  = rsp_gcol_ff;
      rsp_bits_in  = rsp_bits_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_gcol_in  = gcol_ff;
         rsp_bits_in  = col_bits;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         gcol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         gcol_ff      <= gcol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      rsp_gcol_ff <= rsp_gcol_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   // module 3 is leftmost, so the module index is the inverted upper column bits
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.module_index = ~rsp_gcol_ff[GCOL_W-1:COL_W];
   assign rsp_bus.column_index = rsp_gcol_ff[COL_W-1:0];
   assign rsp_bus.column_bits  = rsp_bits_ff;
   assign rsp_bus.last         = (rsp_gcol_ff == LAST_GCOL);

endmodule
`default_nettype wire

/* rtl/core/cmcr_checker.sv */
`default_nettype none
module cmcr_checker import cmcr_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [MOD_W-1:0]  rsp_module_index,
   input wire logic [COL_W-1:0]  rsp_column_index,
   input wire logic [BITS_W-1:0] rsp_column_bits,
   input wire logic              rsp_last
);

   // stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column_bits)
         && $stable(rsp_module_index) && $stable(rsp_column_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // last marks the rightmost column of module 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_module_index == '0 && rsp_column_index == '1))
      else $error("last flag misplaced");

   // columns of one refresh follow back to back in order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid &&
         (($past(rsp_column_index) == '1) ?
            (rsp_column_index == '0 && rsp_module_index == $past(rsp_module_index) - 1'b1) :
            (rsp_column_index == $past(rsp_column_index) + 1'b1 &&
             rsp_module_index == $past(rsp_module_index))))
      else $error("column order broken");

   // no new refresh taken while an unfinished refresh is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !rsp_last |-> !req_ready)
      else $error("refresh accepted mid frame");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind clock_matrix_column_renderer_core cmcr_checker u_cmcr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_module_index (rsp_bus.module_index),
   .rsp_column_index (rsp_bus.column_index),
   .rsp_column_bits  (rsp_bus.column_bits),
   .rsp_last         (rsp_bus.last)
);
`default_nettype wire
